[hw/rtl/dpcp_pkg.sv]
// ----------------------------------------------------------------------------
// dpcp_pkg: shared definitions of the depth colormap and point block
// Widths, register indexes, reset values, colour constants and the
// command/status and configuration structures used between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcp_pkg;

  // Fixed field widths
  localparam int unsigned DEPTH_W    = 13;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned POS_X_W    = 11;
  localparam int unsigned POS_Y_W    = 12;
  localparam int unsigned SIZE_W     = 12;

  // Pixel counters cover the widest supported row
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned COUNT_W    = $clog2(MAX_WIDTH);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(MAX_WIDTH - 1);

  // Divider: quotient of (d-min)*255 by (max-min) never exceeds 255
  localparam int unsigned QUO_W      = COLOR_W;
  localparam int unsigned STEP_W     = $clog2(QUO_W);
  localparam int unsigned NUM_W      = DEPTH_W + COLOR_W;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(QUO_W - 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DEPTH_W;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;

  localparam logic [DEPTH_W-1:0] RANGE_MIN_RST    = 13'd0;
  localparam logic [DEPTH_W-1:0] RANGE_MAX_RST    = 13'd4500;
  localparam logic [SIZE_W-1:0]  IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0]  IMAGE_HEIGHT_RST = 12'd480;

  // Colour constants
  localparam logic [COLOR_W-1:0] GRAY_MAX   = 8'hFF;
  localparam logic [COLOR_W-1:0] GRAY_MID   = 8'h7F;
  // 255 - 2*(g-127) rewritten as this base minus 2*(g-128)
  localparam logic [COLOR_W-1:0] GREEN_FALL = GRAY_MAX - 8'd2;

  typedef struct packed {
    logic [DEPTH_W-1:0] range_min;
    logic [DEPTH_W-1:0] range_max;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture a new sample
    logic step;   // one divider iteration
    logic emit;   // load the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;  // the current iteration is the final one
  } ctl_sts_t;

endpackage

`default_nettype wire

[hw/rtl/depth_pixel_colormap_and_point_top.sv]
// Flow: capture the sample, run the 8-step restoring divider (one quotient bit
//   per cycle), then load the output register once the output is free. The input
//   is stalled from capture until that output load, so one sample is in work at a time.
// A new sample is taken while the previous beat still waits at the output.
// Reset (rst_ni low, asynchronous): pixel counters cleared, configuration to
//   defaults, no beat pending.
// ----------------------------------------------------------------------------
// depth_pixel_colormap_and_point_top: depth pseudo-colour and point generator
// Maps each raster-order depth sample to a colour and a 3D point.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_colormap_and_point_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dpcp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [dpcp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample input
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dpcp_pkg::DEPTH_W-1:0]       depth_sample_i,
  input  wire logic                               frame_start_i,
  // result output
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [dpcp_pkg::COLOR_W-1:0]            red_o,
  output logic [dpcp_pkg::COLOR_W-1:0]            green_o,
  output logic [dpcp_pkg::COLOR_W-1:0]            blue_o,
  output logic                                    point_valid_o,
  output logic [dpcp_pkg::POS_X_W-1:0]            point_x_o,
  output logic [dpcp_pkg::POS_Y_W-1:0]            point_y_o,
  output logic [dpcp_pkg::DEPTH_W-1:0]            point_z_o,
  output logic                                    frame_end_o
);

  dpcp_pkg::cfg_t     cfg;
  dpcp_pkg::ctl_cmd_t cmd;
  dpcp_pkg::ctl_sts_t sts;

  dpcp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpcp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .depth_sample_i (depth_sample_i),
    .frame_start_i  (frame_start_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .point_valid_o  (point_valid_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .frame_end_o    (frame_end_o)
  );

  // Checks

  // accepted sample keeps the input busy through the divider
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_busy_through_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##8 in_stall_o)
    else $error("input free before division finished");

  // out-of-range beats are white with a cleared point
  a_invalid_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !point_valid_o) |->
      (red_o == dpcp_pkg::GRAY_MAX) && (green_o == dpcp_pkg::GRAY_MAX)
      && (blue_o == dpcp_pkg::GRAY_MAX) && (point_x_o == '0)
      && (point_y_o == '0) && (point_z_o == '0))
    else $error("invalid point not white or not cleared");

  // lower half of the colour ramp: green tracks red
  a_low_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_valid_o && !red_o[dpcp_pkg::COLOR_W-1]) |->
      (green_o == dpcp_pkg::GRAY_MID + red_o))
    else $error("green does not follow red on lower ramp");

endmodule

`default_nettype wire

[hw/rtl/dpcp_regs.sv]
// ----------------------------------------------------------------------------
// dpcp_regs: configuration register file
// Holds range bounds and image size; written through a valid/ready port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcp_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dpcp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [dpcp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output dpcp_pkg::cfg_t                          cfg_o
);

  dpcp_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dpcp_pkg::REG_RANGE_MIN:    cfg_d.range_min    = cfg_data_i;
        dpcp_pkg::REG_RANGE_MAX:    cfg_d.range_max    = cfg_data_i;
        dpcp_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[dpcp_pkg::SIZE_W-1:0];
        dpcp_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[dpcp_pkg::SIZE_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_min    <= dpcp_pkg::RANGE_MIN_RST;
      cfg_q.range_max    <= dpcp_pkg::RANGE_MAX_RST;
      cfg_q.image_width  <= dpcp_pkg::IMAGE_WIDTH_RST;
      cfg_q.image_height <= dpcp_pkg::IMAGE_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/dpcp_ctrl.sv]
// ----------------------------------------------------------------------------
// dpcp_ctrl: sequencing state machine
// Accepts a sample, runs the divider iterations, then hands the result to
// the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire dpcp_pkg::ctl_sts_t  sts_i,
  output dpcp_pkg::ctl_cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output register can take a beat when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/dpcp_datapath.sv]
// ----------------------------------------------------------------------------
// dpcp_datapath: pixel position, range test, divider and colour mapping
// Restoring divider yields one quotient bit per step; the output register
// holds the finished beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcp_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire dpcp_pkg::cfg_t                     cfg_i,
  input  wire dpcp_pkg::ctl_cmd_t                 cmd_i,
  output dpcp_pkg::ctl_sts_t                      sts_o,
  input  wire logic [dpcp_pkg::DEPTH_W-1:0]       depth_sample_i,
  input  wire logic                               frame_start_i,
  output logic [dpcp_pkg::COLOR_W-1:0]            red_o,
  output logic [dpcp_pkg::COLOR_W-1:0]            green_o,
  output logic [dpcp_pkg::COLOR_W-1:0]            blue_o,
  output logic                                    point_valid_o,
  output logic [dpcp_pkg::POS_X_W-1:0]            point_x_o,
  output logic [dpcp_pkg::POS_Y_W-1:0]            point_y_o,
  output logic [dpcp_pkg::DEPTH_W-1:0]            point_z_o,
  output logic                                    frame_end_o
);

  localparam int unsigned DW = dpcp_pkg::DEPTH_W;
  localparam int unsigned NW = dpcp_pkg::NUM_W;
  localparam int unsigned CW = dpcp_pkg::COLOR_W;
  localparam int unsigned KW = dpcp_pkg::COUNT_W;
  localparam int unsigned SW = dpcp_pkg::SIZE_W;

  // Pixel counters (control state)
  logic [KW-1:0] col_q, col_d, row_q, row_d;

  // Item registers (payload)
  logic [NW-1:0]                    rem_q, rem_d;
  logic [DW-1:0]                    den_q;
  logic [dpcp_pkg::QUO_W-1:0]       quo_q, quo_d;
  logic [dpcp_pkg::STEP_W-1:0]      step_q, step_d;
  logic                             in_range_q, zero_den_q, frame_end_q;
  logic [dpcp_pkg::POS_X_W-1:0]     pos_x_q;
  logic [dpcp_pkg::POS_Y_W-1:0]     pos_y_q;
  logic [DW-1:0]                    diff_q;

  // Output registers (payload)
  logic [CW-1:0]                    red_q, green_q, blue_q;
  logic                             pvalid_q, fend_q;
  logic [dpcp_pkg::POS_X_W-1:0]     px_q;
  logic [dpcp_pkg::POS_Y_W-1:0]     py_q;
  logic [DW-1:0]                    pz_q;

  // Position of this sample; frame start clears it first
  logic [KW-1:0] col_use, row_use;
  logic          last_col, last_row;

  assign col_use  = frame_start_i ? '0 : col_q;
  assign row_use  = frame_start_i ? '0 : row_q;
  assign last_col = ({1'b0, col_use} + 1'b1 >= cfg_i.image_width)
                    || (col_use == dpcp_pkg::COUNT_LAST);
  assign last_row = ({1'b0, row_use} + 1'b1 >= cfg_i.image_height)
                    || (row_use == dpcp_pkg::COUNT_LAST);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_use + 1'b1;
      end else begin
        col_d = col_use + 1'b1;
        row_d = row_use;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Range test and divider operands
  logic          in_range;
  logic [DW-1:0] diff, den;
  logic [NW-1:0] num_scaled;

  assign in_range   = (depth_sample_i >= cfg_i.range_min)
                      && (depth_sample_i <= cfg_i.range_max);
  assign diff       = depth_sample_i - cfg_i.range_min;
  assign den        = cfg_i.range_max - cfg_i.range_min;
  // diff*255 = diff*256 - diff
  assign num_scaled = (NW'(diff) << CW) - NW'(diff);

  // Divider iteration: compare with the divisor shifted to this bit
  logic [NW-1:0] den_shift;
  logic          fits;

  assign den_shift       = NW'(den_q) << step_q;
  assign fits            = rem_q >= den_shift;
  assign sts_o.div_last  = (step_q == '0);

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (cmd_i.load) begin
      // ceiling: add den-1 before the floor division
      rem_d  = num_scaled + NW'(den) - NW'(1);
      quo_d  = '0;
      step_d = dpcp_pkg::STEP_FIRST;
    end else if (cmd_i.step) begin
      if (fits) begin
        rem_d         = rem_q - den_shift;
        quo_d[step_q] = 1'b1;
      end
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    if (cmd_i.load) begin
      den_q       <= den;
      diff_q      <= diff;
      in_range_q  <= in_range;
      zero_den_q  <= (den == '0);
      frame_end_q <= last_col && last_row;
      pos_x_q     <= dpcp_pkg::POS_X_W'(col_use);
      pos_y_q     <= cfg_i.image_height - SW'(row_use);
    end
  end

  // Colour mapping from the gray level
  logic [CW-1:0] gray, gray_x2, red_c, green_c, blue_c;

  assign gray    = zero_den_q ? dpcp_pkg::GRAY_MAX : dpcp_pkg::GRAY_MAX - quo_q;
  assign gray_x2 = {gray[CW-2:0], 1'b0};

  always_comb begin
    if (!in_range_q) begin
      red_c   = dpcp_pkg::GRAY_MAX;
      green_c = dpcp_pkg::GRAY_MAX;
      blue_c  = dpcp_pkg::GRAY_MAX;
    end else if (!gray[CW-1]) begin
      red_c   = gray;
      green_c = dpcp_pkg::GRAY_MID + gray;
      blue_c  = dpcp_pkg::GRAY_MAX - gray_x2;
    end else begin
      red_c   = gray;
      green_c = dpcp_pkg::GREEN_FALL - gray_x2;
      blue_c  = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      red_q    <= red_c;
      green_q  <= green_c;
      blue_q   <= blue_c;
      pvalid_q <= in_range_q;
      px_q     <= in_range_q ? pos_x_q : '0;
      py_q     <= in_range_q ? pos_y_q : '0;
      pz_q     <= in_range_q ? diff_q  : '0;
      fend_q   <= frame_end_q;
    end
  end

  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign point_valid_o = pvalid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_z_o     = pz_q;
  assign frame_end_o   = fend_q;

endmodule

`default_nettype wire

[sim/depth_pixel_colormap_and_point_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_colormap_and_point_top_tb: self-checking bench of the depth
// colormap and point block
// Streams raster depth samples through the block under several range and
// frame-size settings, predicts colour, point and frame end for each sample
// and compares every output beat field by field, with random gaps on both
// the sample and result channels.
// ----------------------------------------------------------------------------

module depth_pixel_colormap_and_point_top_tb;

  typedef struct packed {
    logic [dpcp_pkg::COLOR_W-1:0] red;
    logic [dpcp_pkg::COLOR_W-1:0] green;
    logic [dpcp_pkg::COLOR_W-1:0] blue;
    logic                         point_valid;
    logic [dpcp_pkg::POS_X_W-1:0] point_x;
    logic [dpcp_pkg::POS_Y_W-1:0] point_y;
    logic [dpcp_pkg::DEPTH_W-1:0] point_z;
    logic                         frame_end;
  } px_result_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_valid_i    = 1'b0;
  logic                            cfg_ready_o;
  logic [dpcp_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [dpcp_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_stall_o;
  logic [dpcp_pkg::DEPTH_W-1:0]    depth_sample_i = '0;
  logic                            frame_start_i  = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i    = 1'b0;
  logic [dpcp_pkg::COLOR_W-1:0]    red_o;
  logic [dpcp_pkg::COLOR_W-1:0]    green_o;
  logic [dpcp_pkg::COLOR_W-1:0]    blue_o;
  logic                            point_valid_o;
  logic [dpcp_pkg::POS_X_W-1:0]    point_x_o;
  logic [dpcp_pkg::POS_Y_W-1:0]    point_y_o;
  logic [dpcp_pkg::DEPTH_W-1:0]    point_z_o;
  logic                            frame_end_o;

  // Mirror of the block's registers and pixel counters
  logic [dpcp_pkg::DEPTH_W-1:0] cfg_min    = dpcp_pkg::RANGE_MIN_RST;
  logic [dpcp_pkg::DEPTH_W-1:0] cfg_max    = dpcp_pkg::RANGE_MAX_RST;
  logic [dpcp_pkg::SIZE_W-1:0]  cfg_width  = dpcp_pkg::IMAGE_WIDTH_RST;
  logic [dpcp_pkg::SIZE_W-1:0]  cfg_height = dpcp_pkg::IMAGE_HEIGHT_RST;
  int unsigned                  col_cnt    = 0;
  int unsigned                  row_cnt    = 0;

  px_result_t  pending_px_q[$];
  int unsigned errors      = 0;
  int unsigned in_gap_max  = 0;
  int unsigned out_gap_max = 0;
  int unsigned stall_left  = 0;

  depth_pixel_colormap_and_point_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .depth_sample_i (depth_sample_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .point_valid_o  (point_valid_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .frame_end_o    (frame_end_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Colour, point and frame end of one sample; advances the pixel counters
  function automatic px_result_t colorize_pixel(
      input logic [dpcp_pkg::DEPTH_W-1:0] depth, input logic fs);
    px_result_t  px;
    int unsigned den, num, gray, grn;
    bit          in_rng, col_last, row_last;
    px = '0;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    in_rng = (depth >= cfg_min) && (depth <= cfg_max);
    if (in_rng) begin
      den  = cfg_max - cfg_min;
      gray = dpcp_pkg::GRAY_MAX;
      if (den != 0) begin
        num  = (depth - cfg_min) * 255;
        gray = 255 - (num + den - 1) / den;
      end
      px.red = dpcp_pkg::COLOR_W'(gray);
      if (gray <= dpcp_pkg::GRAY_MID) begin
        grn     = dpcp_pkg::GRAY_MID + gray;
        px.blue = dpcp_pkg::COLOR_W'(255 - 2 * gray);
      end else begin
        // wraps to 255 at the nearest depth
        grn     = 255 - 2 * (gray - dpcp_pkg::GRAY_MID);
        px.blue = '0;
      end
      px.green   = dpcp_pkg::COLOR_W'(grn);
      px.point_x = dpcp_pkg::POS_X_W'(col_cnt);
      px.point_y = dpcp_pkg::POS_Y_W'(cfg_height - row_cnt);
      px.point_z = dpcp_pkg::DEPTH_W'(depth - cfg_min);
    end else begin
      px.red   = dpcp_pkg::GRAY_MAX;
      px.green = dpcp_pkg::GRAY_MAX;
      px.blue  = dpcp_pkg::GRAY_MAX;
    end
    px.point_valid = in_rng;

    col_last     = (col_cnt + 1 >= cfg_width) || (col_cnt >= dpcp_pkg::COUNT_LAST);
    row_last     = (row_cnt + 1 >= cfg_height) || (row_cnt >= dpcp_pkg::COUNT_LAST);
    px.frame_end = col_last && row_last;
    if (col_last) begin
      col_cnt = 0;
      row_cnt = row_last ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return px;
  endfunction

  // One sample beat; valid is left high so a back-to-back beat keeps it up
  task automatic send_sample(input logic [dpcp_pkg::DEPTH_W-1:0] depth, input logic fs);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    cfg_valid_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    depth_sample_i <= depth;
    frame_start_i  <= fs;
    do @(posedge clk_i); while (in_stall_o);
    pending_px_q.push_back(colorize_pixel(depth, fs));
  endtask

  // Block is idle once every predicted beat has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_px_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dpcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpcp_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dpcp_pkg::REG_RANGE_MIN:    cfg_min    = data;
      dpcp_pkg::REG_RANGE_MAX:    cfg_max    = data;
      dpcp_pkg::REG_IMAGE_WIDTH:  cfg_width  = data[dpcp_pkg::SIZE_W-1:0];
      dpcp_pkg::REG_IMAGE_HEIGHT: cfg_height = data[dpcp_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // Depth mostly near the colour range, sometimes anywhere
  function automatic logic [dpcp_pkg::DEPTH_W-1:0] pick_depth();
    int lo, hi;
    if ($urandom_range(0, 7) == 0 || cfg_min > cfg_max) begin
      return dpcp_pkg::DEPTH_W'($urandom);
    end
    lo = int'(cfg_min) - 4;
    hi = int'(cfg_max) + 4;
    if (lo < 0) lo = 0;
    if (hi > 8191) hi = 8191;
    return dpcp_pkg::DEPTH_W'($urandom_range(hi, lo));
  endfunction

  // Frame start mostly on the first pixel, with the odd stray one mid-frame
  function automatic logic pick_frame_start();
    if (col_cnt == 0 && row_cnt == 0) return ($urandom_range(0, 3) != 0);
    return ($urandom_range(0, 39) == 0);
  endfunction

  // Mostly tiny frames; now and then large, zero or oversize
  function automatic logic [dpcp_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return dpcp_pkg::SIZE_W'($urandom_range(9, 2048));
      1:       return dpcp_pkg::SIZE_W'($urandom);
      default: return dpcp_pkg::SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    px_result_t exp_px;
    if (pending_px_q.size() == 0) begin
      errors++;
      $display("%0t ns: output beat with no pending sample, rgb %0d/%0d/%0d xyz %0d/%0d/%0d",
               $time, red_o, green_o, blue_o, point_x_o, point_y_o, point_z_o);
    end else begin
      exp_px = pending_px_q.pop_front();
      check_field("red",         exp_px.red,         red_o);
      check_field("green",       exp_px.green,       green_o);
      check_field("blue",        exp_px.blue,        blue_o);
      check_field("point_valid", exp_px.point_valid, point_valid_o);
      check_field("point_x",     exp_px.point_x,     point_x_o);
      check_field("point_y",     exp_px.point_y,     point_y_o);
      check_field("point_z",     exp_px.point_z,     point_z_o);
      check_field("frame_end",   exp_px.frame_end,   frame_end_o);
    end
  endtask

  // Result side: check each beat, then stall a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Reset values, colour ends, white out of range, green/blue knee
  task automatic test_reset_defaults();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_sample(13'd0,    1'b1);
    send_sample(13'd4500, 1'b0);
    send_sample(13'd4501, 1'b0);
    send_sample(13'd8191, 1'b0);
    send_sample(13'd2250, 1'b0);
    send_sample(13'd2241, 1'b0);
    send_sample(13'd2242, 1'b0);
    send_sample(13'd1,    1'b1);
  endtask

  // Equal, inverted and full-scale range bounds
  task automatic test_range_bounds();
    in_gap_max  = 14;
    out_gap_max = 14;
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd1000);
    write_reg(dpcp_pkg::REG_RANGE_MAX, 13'd1000);
    send_sample(13'd999,  1'b1);
    send_sample(13'd1000, 1'b0);
    send_sample(13'd1001, 1'b0);
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd5000);
    write_reg(dpcp_pkg::REG_RANGE_MAX, 13'd100);
    send_sample(13'd100,  1'b0);
    send_sample(13'd5000, 1'b0);
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd0);
    write_reg(dpcp_pkg::REG_RANGE_MAX, 13'd8191);
    send_sample(13'd0,    1'b0);
    send_sample(13'd8191, 1'b0);
    send_sample(13'd4096, 1'b0);
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd8191);
    send_sample(13'd8191, 1'b0);
  endtask

  // Frame wrap, zero size, size change mid-frame, largest frame
  task automatic test_frame_geometry();
    in_gap_max  = 5;
    out_gap_max = 5;
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd0);
    write_reg(dpcp_pkg::REG_RANGE_MAX, 13'd8191);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd2);
    send_sample(13'd10, 1'b1);
    send_sample(13'd20, 1'b0);
    send_sample(13'd30, 1'b0);
    send_sample(13'd40, 1'b0);
    send_sample(13'd50, 1'b0);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd0);
    send_sample(13'd60, 1'b0);
    send_sample(13'd70, 1'b0);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd3);
    send_sample(13'd80, 1'b1);
    send_sample(13'd90, 1'b0);
    // row now beyond the new height, so point_y wraps
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd1);
    send_sample(13'd100, 1'b0);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd2048);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd2048);
    send_sample(13'd110, 1'b1);
    send_sample(13'd120, 1'b0);
  endtask

  // Random settings and frames with random content and frame starts
  task automatic test_random_frames();
    logic [dpcp_pkg::DEPTH_W-1:0] lo, hi, tmp;
    for (int ph = 0; ph < 12; ph++) begin
      lo = dpcp_pkg::DEPTH_W'($urandom);
      hi = dpcp_pkg::DEPTH_W'($urandom);
      case ($urandom_range(0, 9))
        0: hi = lo;
        1: begin
          lo = '0;
          hi = '1;
        end
        2: ;  // either order, inverted included
        default: if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      endcase
      write_reg(dpcp_pkg::REG_RANGE_MIN, lo);
      write_reg(dpcp_pkg::REG_RANGE_MAX, hi);
      write_reg(dpcp_pkg::REG_IMAGE_WIDTH, {1'b0, pick_size()});
      write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, {1'b0, pick_size()});
      case (ph % 3)
        0:       in_gap_max = 14;
        1:       in_gap_max = 0;
        default: in_gap_max = 3;
      endcase
      out_gap_max = (ph % 4 == 1) ? 0 : 14;
      for (int i = 0; i < 60; i++) send_sample(pick_depth(), pick_frame_start());
    end
  endtask

  // Oversize frames: width, then height set past the counter range of the widest row
  task automatic test_counter_limit();
    in_gap_max  = 1;
    out_gap_max = 1;
    write_reg(dpcp_pkg::REG_RANGE_MIN, 13'd0);
    write_reg(dpcp_pkg::REG_RANGE_MAX, 13'd8191);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd4095);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd2);
    send_sample(pick_depth(), 1'b1);
    for (int i = 0; i < 50; i++) send_sample(pick_depth(), 1'b0);
    write_reg(dpcp_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(dpcp_pkg::REG_IMAGE_HEIGHT, 13'd4095);
    send_sample(pick_depth(), 1'b1);
    for (int i = 0; i < 50; i++) send_sample(pick_depth(), 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_range_bounds();
    test_frame_geometry();
    test_random_frames();
    test_counter_limit();
    wait_idle();
    cfg_valid_i <= 1'b0;
    // catch any stray beat after the last expected one
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
